/* design/msk_pkg.sv */
// msk_pkg: types and codes shared by the min-tracking stack
// item structs, opcode and status codes, default depth
// no dependencies
`default_nettype none

package msk_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int DATA_W    = 32;
	localparam int ENTRY_W   = 2 * DATA_W;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] push_value;
	} op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] current_minimum;
		logic                     is_empty;
		logic                     is_full;
		logic [1:0]               status;
	} res_t;

endpackage

`default_nettype wire

/* design/msk_ram.sv */
// msk_ram: generic simple dual-port ram, one write and one registered read port
// depends on msk_pkg for default width
`default_nettype none

module msk_ram #(
	parameter int WIDTH = msk_pkg::ENTRY_W,
	parameter int DEPTH = msk_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/min_tracking_stack.sv */
// min_tracking_stack: bounded signed stack that tracks the minimum of its contents
// depends on msk_pkg and msk_ram
`default_nettype none

// Each item is a push, a pop or a minimum query and gives exactly one result item.
// Every entry holds its value and the minimum of itself and all entries below it,
// in one entry RAM; the top entry is also held in registers. A pop of a stack that
// holds two or more entries passes through a fill state, since the new top entry is
// read back from the registered read port of the RAM; a pop that empties the stack
// and a push or a query complete without it. Results are registered and appear the
// cycle after the item completes; a waiting result does not block the next item
// unless it is stalled. Underflow and overflow are reported in status and leave the
// stack unchanged. The RAM is not cleared after reset; no reset pass runs.

module min_tracking_stack #(
	parameter int DEPTH = msk_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output logic               op_stall,
	input  wire msk_pkg::op_t  op,
	output logic               res_valid,
	input  wire logic          res_stall,
	output msk_pkg::res_t      res
);

	import msk_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);
	localparam logic [CW-1:0] COUNT_ONE = CW'(1);
	localparam logic [CW-1:0] COUNT_TWO = CW'(2);

	typedef enum logic {
		S_IDLE,
		S_FILL
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] top_val_q;
	logic signed [DATA_W-1:0] top_min_q;
	logic                     res_valid_q;
	res_t                     res_q;

	logic                     acc;
	logic                     is_push;
	logic                     is_pop;
	logic                     empty;
	logic                     full;
	logic signed [DATA_W-1:0] push_min;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [AW-1:0]            ram_raddr;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic signed [DATA_W-1:0] rd_val;
	logic signed [DATA_W-1:0] rd_min;

	assign op_stall  = (state_q == S_FILL) || (res_valid_q && res_stall);
	assign acc       = op_valid && !op_stall;
	assign is_push   = (op.opcode == OP_PUSH);
	assign is_pop    = (op.opcode == OP_POP);
	assign empty     = (count_q == '0);
	assign full      = (count_q == COUNT_MAX);
	assign push_min  = (empty || (op.push_value <= top_min_q)) ? op.push_value : top_min_q;

	assign ram_we    = acc && is_push && !full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = {op.push_value, push_min};
	assign ram_raddr = AW'(count_q - COUNT_TWO);
	assign rd_val    = ram_rdata[ENTRY_W-1:DATA_W];
	assign rd_min    = ram_rdata[DATA_W-1:0];

	assign res_valid = res_valid_q;
	assign res       = res_q;

	msk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_val_q   <= '0;
			top_min_q   <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_valid_q           <= 1'b1;
						res_q.popped_value    <= '0;
						res_q.current_minimum <= empty ? '0 : top_min_q;
						res_q.is_empty        <= empty;
						res_q.is_full         <= full;
						res_q.status          <= ST_OK;
						if (is_push) begin
							if (full) begin
								res_q.status <= ST_OVER;
							end else begin
								count_q               <= count_q + COUNT_ONE;
								top_val_q             <= op.push_value;
								top_min_q             <= push_min;
								res_q.current_minimum <= push_min;
								res_q.is_empty        <= 1'b0;
								res_q.is_full         <= ((count_q + COUNT_ONE) == COUNT_MAX);
							end
						end else if (is_pop) begin
							if (empty) begin
								res_q.status <= ST_UNDER;
							end else begin
								count_q            <= count_q - COUNT_ONE;
								res_q.popped_value <= top_val_q;
								res_q.is_empty     <= (count_q == COUNT_ONE);
								res_q.is_full      <= 1'b0;
								if (count_q == COUNT_ONE) begin
									res_q.current_minimum <= '0;
								end else begin
									res_valid_q <= 1'b0;
									state_q     <= S_FILL;
								end
							end
						end else if (empty) begin
							res_q.status <= ST_UNDER;
						end
					end
				end
				S_FILL: begin
					top_val_q             <= rd_val;
					top_min_q             <= rd_min;
					res_q.current_minimum <= rd_min;
					res_valid_q           <= 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("entry count beyond depth");

	a_fill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_pop && (count_q > COUNT_ONE)) |=> (state_q == S_FILL))
		else $error("pop of deep stack did not refill top");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(count_q))
		else $error("entry count moved without an item");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.is_empty && res_q.is_full))
		else $error("result flagged both empty and full");
`endif

endmodule

`default_nettype wire

/* tb/min_tracking_stack_tb.sv */
// min_tracking_stack_tb: self-checking bench for the min-tracking stack
// shadow stack predicts every result item, random idling on both channels
// depends on msk_pkg and min_tracking_stack
`default_nettype none

module min_tracking_stack_tb;
	import msk_pkg::*;

	localparam int STACK_DEPTH = DEPTH_DEF;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	op_t  op;
	logic res_valid;
	logic res_stall;
	res_t res;

	min_tracking_stack #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the stack
	logic signed [DATA_W-1:0] shadow_values [STACK_DEPTH];
	logic signed [DATA_W-1:0] shadow_minima [STACK_DEPTH];
	int unsigned shadow_count;

	res_t pending_results[$];
	bit   idle_on;
	int   errors;
	int   n_sent, n_checked, n_push, n_pop, n_under, n_over, n_full;

	function automatic res_t stack_predict(op_t item);
		res_t r;
		r = '0;
		r.status = ST_OK;
		if (item.opcode == OP_PUSH) begin
			if (shadow_count >= STACK_DEPTH) begin
				r.status = ST_OVER;
				n_over++;
			end else begin
				shadow_values[shadow_count] = item.push_value;
				if (shadow_count > 0 && !(item.push_value <= shadow_minima[shadow_count-1]))
					shadow_minima[shadow_count] = shadow_minima[shadow_count-1];
				else
					shadow_minima[shadow_count] = item.push_value;
				shadow_count++;
				n_push++;
			end
		end else if (item.opcode == OP_POP) begin
			if (shadow_count == 0) begin
				r.status = ST_UNDER;
				n_under++;
			end else begin
				shadow_count--;
				r.popped_value = shadow_values[shadow_count];
				n_pop++;
			end
		end else if (shadow_count == 0) begin
			r.status = ST_UNDER;
			n_under++;
		end
		r.current_minimum = (shadow_count == 0) ? '0 : shadow_minima[shadow_count-1];
		r.is_empty = (shadow_count == 0);
		r.is_full  = (shadow_count >= STACK_DEPTH);
		if (r.is_full)
			n_full++;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result item with nothing expected (%h)", got));
		end else begin
			want = pending_results.pop_front();
			n_checked++;
			if (got.popped_value !== want.popped_value)
				report_mismatch($sformatf("popped_value %0d, expected %0d",
					got.popped_value, want.popped_value));
			if (got.current_minimum !== want.current_minimum)
				report_mismatch($sformatf("current_minimum %0d, expected %0d",
					got.current_minimum, want.current_minimum));
			if (got.is_empty !== want.is_empty)
				report_mismatch($sformatf("is_empty %b, expected %b",
					got.is_empty, want.is_empty));
			if (got.is_full !== want.is_full)
				report_mismatch($sformatf("is_full %b, expected %b",
					got.is_full, want.is_full));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d",
					got.status, want.status));
		end
	endtask

	// result side: random stall before each item, then take it
	always begin : result_side
		int hold;
		hold = idle_on ? $urandom_range(0, 5) : 0;
		if (hold > 0) begin
			res_stall <= 1'b1;
			repeat (hold) @(posedge clk);
		end
		res_stall <= 1'b0;
		do @(posedge clk); while (!(res_valid && arst_n === 1'b1));
		check_result(res);
	end

	task automatic send_op(logic [1:0] code, logic signed [DATA_W-1:0] value);
		int gap;
		op_t item;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		item.opcode = code;
		item.push_value = value;
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		op <= item;
		do @(posedge clk); while (op_stall);
		pending_results.push_back(stack_predict(item));
		n_sent++;
	endtask

	task automatic wait_drain();
		op_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 40) - 20;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_stack();
		idle_on = 1'b1;
		send_op(OP_POP, rand_value());
		send_op(OP_QUERY, rand_value());
		send_op(OP_SPARE, rand_value());
	endtask

	task automatic test_extremes();
		idle_on = 1'b0;
		send_op(OP_PUSH, 32'sh7fffffff);
		send_op(OP_QUERY, $urandom);
		send_op(OP_PUSH, 32'sh80000000);
		send_op(OP_PUSH, 32'sh0);
		send_op(OP_PUSH, -32'sd1);
		send_op(OP_SPARE, $urandom);
		send_op(OP_POP, $urandom);
		send_op(OP_POP, $urandom);
		send_op(OP_POP, $urandom);
		// equal value on top of the minimum
		send_op(OP_PUSH, 32'sh7fffffff);
		send_op(OP_POP, $urandom);
		send_op(OP_POP, $urandom);
		send_op(OP_POP, $urandom);
		send_op(OP_PUSH, 32'sh55555555);
		send_op(OP_PUSH, 32'shaaaaaaaa);
		send_op(OP_QUERY, $urandom);
		send_op(OP_POP, $urandom);
		send_op(OP_POP, $urandom);
	endtask

	task automatic test_fill_drain();
		idle_on = 1'b1;
		while (shadow_count < STACK_DEPTH)
			send_op(OP_PUSH, rand_value());
		send_op(OP_PUSH, rand_value());
		send_op(OP_PUSH, rand_value());
		send_op(OP_QUERY, rand_value());
		wait_drain();
		while (shadow_count > 0)
			send_op(OP_POP, rand_value());
		send_op(OP_POP, rand_value());
		wait_drain();
	endtask

	task automatic test_random_walk(int n_items, int push_pct, bit with_gaps);
		int i, pick, rest, span;
		logic [1:0] code;
		idle_on = with_gaps;
		span = 100 - push_pct;
		for (i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			rest = pick - push_pct;
			if (pick < push_pct)
				code = OP_PUSH;
			else if (rest * 10 < span * 7)
				code = OP_POP;
			else if (rest * 10 < span * 9)
				code = OP_QUERY;
			else
				code = OP_SPARE;
			send_op(code, rand_value());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		op <= '0;
		idle_on = 1'b0;
		errors = 0;
		shadow_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_extremes();
		test_fill_drain();
		test_random_walk(150, 50, 1'b1);
		test_random_walk(220, 80, 1'b1);
		wait_drain();
		test_random_walk(150, 25, 1'b0);
		test_random_walk(150, 60, 1'b1);
		test_random_walk(100, 50, 1'b0);

		op_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items sent: %0d pushes, %0d pops, %0d underflows, %0d overflows",
			n_sent, n_push, n_pop, n_under, n_over);
		$display("%0d results checked, %0d of them with the stack full",
			n_checked, n_full);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
